/* rtl/qspd_pkg.sv */
// ----------------------------------------------------------------------------
// qspd_pkg
// Shared types, character codes and the escape digit function for the
// query-string pair decoder.
// ----------------------------------------------------------------------------
package qspd_pkg;

   localparam logic [7:0] CHAR_AMP      = 8'h26;
   localparam logic [7:0] CHAR_PLUS     = 8'h2b;
   localparam logic [7:0] CHAR_PERCENT  = 8'h25;
   localparam logic [7:0] CHAR_EQUALS   = 8'h3d;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] ALPHA_LOW     = 8'h41;
   localparam logic [7:0] ALPHA_HIGH    = 8'h7f;
   localparam logic [7:0] CASE_MASK     = 8'hdf;
   localparam logic [7:0] ALPHA_OFFSET  = 8'd10;

   typedef enum logic [1:0] {
      KIND_NAME  = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_NONE   = 2'd0,
      PHASE_FIRST  = 2'd1,
      PHASE_SECOND = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type  escape_phase;
      logic [7:0] escape_high;
      logic       in_value_part;
      logic       pair_dead;
   } pair_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   out_kind;
      logic       out_last;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0] count;
      logic       room;
   } queue_status_type;

   // 8-bit wrapping digit value, accepts any byte
   function automatic logic [7:0] digit_value(input logic [7:0] u);
      logic [7:0] d;
      if (u >= ALPHA_LOW && u <= ALPHA_HIGH) begin
         d = (u & CASE_MASK) - ALPHA_LOW + ALPHA_OFFSET;
      end else begin
         d = u - CHAR_ZERO;
      end
      return d;
   endfunction

endpackage

/* rtl/query_string_pair_decoder_top.sv */
// ----------------------------------------------------------------------------
// query_string_pair_decoder_top
// Decodes query-string bytes into name bytes, value bytes and pair markers.
//
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    req_in_byte, req_in_last
// rsp      out  rsp_valid/rsp_ready    rsp_out_byte, rsp_out_kind, rsp_out_last
//
// one item per cycle on req while the queue has room; an item yields zero, one or two rsp items
// path: input register, then decode into the four-entry result queue
// decode runs when the queue holds two or fewer items; rsp drains one per cycle while rsp_ready is high
// the sustained rate of items giving two results is set by the rsp port
// synchronous reset clears the pair state, the input valid flag and the queue
// ----------------------------------------------------------------------------
module query_string_pair_decoder_top #(
   parameter int MAX_PAIR_RAW = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_out_kind,
   output logic       rsp_out_last
);
   import qspd_pkg::*;

   localparam int RCW = $clog2(MAX_PAIR_RAW + 1);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   pair_state_type   st_ff, st_in;
   logic [RCW-1:0]   raw_count_ff, raw_count_in;
   logic [1:0]       step_push;
   logic [1:0]       push_count;
   rsp_item_type     item0, item1, out_item;
   queue_status_type status;
   logic             fire;
   logic             req_fire;

   assign fire      = in_valid_ff && status.room;
   assign req_ready = !in_valid_ff || status.room;
   assign req_fire  = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !status.room);
   assign push_count  = fire ? step_push : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         st_ff        <= '0;
         raw_count_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            st_ff        <= st_in;
            raw_count_ff <= raw_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   qspd_step #(
      .MAX_PAIR_RAW (MAX_PAIR_RAW),
      .RCW          (RCW)
   ) u_step (
      .in_byte        (in_byte_ff),
      .in_last        (in_last_ff),
      .st             (st_ff),
      .raw_count      (raw_count_ff),
      .st_next        (st_in),
      .raw_count_next (raw_count_in),
      .push_count     (step_push),
      .item0          (item0),
      .item1          (item1)
   );

   qspd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .item0      (item0),
      .item1      (item1),
      .pop        (rsp_valid && rsp_ready),
      .out_valid  (rsp_valid),
      .out_item   (out_item),
      .status     (status)
   );

   assign rsp_out_byte = out_item.out_byte;
   assign rsp_out_kind = out_item.out_kind;
   assign rsp_out_last = out_item.out_last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      status.count <= 3'd4)
      else $error("result queue overflow");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == KIND_END) |-> (rsp_out_byte == 8'd0 && rsp_out_last))
      else $error("end marker with nonzero byte");

   a_no_bad_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_kind == KIND_NAME || rsp_out_kind == KIND_VALUE ||
                     rsp_out_kind == KIND_END))
      else $error("undefined result kind");

   a_pair_clear: assert property (@(posedge clock) disable iff (reset)
      (fire && (in_last_ff || in_byte_ff == CHAR_AMP)) |=>
         (raw_count_ff == '0 && st_ff == '0))
      else $error("pair state not cleared at pair end");

   a_dead_quiet: assert property (@(posedge clock) disable iff (reset)
      (fire && st_ff.pair_dead && !in_last_ff && in_byte_ff != CHAR_AMP) |->
         push_count == 2'd0)
      else $error("dead pair produced a result");

endmodule

/* rtl/qspd_step.sv */
// ----------------------------------------------------------------------------
// qspd_step
// Per-byte decode: next pair state and up to two result items.
// ----------------------------------------------------------------------------
module qspd_step #(
   parameter int MAX_PAIR_RAW = 256,
   parameter int RCW          = 9
) (
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   input  qspd_pkg::pair_state_type st,
   input  logic [RCW-1:0]          raw_count,
   output qspd_pkg::pair_state_type st_next,
   output logic [RCW-1:0]          raw_count_next,
   output logic [1:0]              push_count,
   output qspd_pkg::rsp_item_type  item0,
   output qspd_pkg::rsp_item_type  item1
);
   import qspd_pkg::*;

   logic       is_amp;
   logic [7:0] c;
   logic [7:0] dig;
   logic [7:0] v;
   logic       have;
   logic       emit;
   kind_type   kind;
   rsp_item_type marker;

   assign marker = '{out_byte: 8'd0, out_kind: KIND_END, out_last: 1'b1};

   always_comb begin
      st_next        = st;
      raw_count_next = raw_count;
      is_amp         = (in_byte == CHAR_AMP);
      c              = (in_byte == CHAR_PLUS) ? CHAR_SPACE : in_byte;
      dig            = digit_value(c);
      v              = 8'd0;
      have           = 1'b0;
      emit           = 1'b0;
      kind           = KIND_NAME;
      if (is_amp) begin
         st_next        = '0;
         raw_count_next = '0;
      end else begin
         if (!st.pair_dead) begin
            if (raw_count >= RCW'(MAX_PAIR_RAW)) begin
               if (st.escape_phase != PHASE_NONE) begin
                  st_next.pair_dead    = 1'b1;
                  st_next.escape_phase = PHASE_NONE;
               end
            end else begin
               raw_count_next = raw_count + RCW'(1);
               if (c == 8'd0) begin
                  st_next.pair_dead    = 1'b1;
                  st_next.escape_phase = PHASE_NONE;
               end else begin
                  case (st.escape_phase)
                     PHASE_NONE: begin
                        if (c == CHAR_PERCENT) begin
                           st_next.escape_phase = PHASE_FIRST;
                        end else begin
                           v    = c;
                           have = 1'b1;
                        end
                     end
                     PHASE_FIRST: begin
                        st_next.escape_high  = {dig[3:0], 4'b0000};
                        st_next.escape_phase = PHASE_SECOND;
                     end
                     PHASE_SECOND: begin
                        v                    = st.escape_high + dig;
                        st_next.escape_phase = PHASE_NONE;
                        have                 = 1'b1;
                     end
                     default: begin
                        st_next.escape_phase = PHASE_NONE;
                     end
                  endcase
               end
               if (have) begin
                  if (v == 8'd0) begin
                     st_next.pair_dead = 1'b1;
                  end else if (!st.in_value_part && v == CHAR_EQUALS) begin
                     st_next.in_value_part = 1'b1;
                  end else begin
                     emit = 1'b1;
                     kind = st.in_value_part ? KIND_VALUE : KIND_NAME;
                  end
               end
            end
         end
         if (in_last) begin
            st_next        = '0;
            raw_count_next = '0;
         end
      end
   end

   always_comb begin
      item1 = marker;
      if (is_amp) begin
         item0      = marker;
         push_count = 2'd1;
      end else if (emit) begin
         item0      = '{out_byte: v, out_kind: kind, out_last: !in_last};
         push_count = in_last ? 2'd2 : 2'd1;
      end else begin
         item0      = marker;
         push_count = in_last ? 2'd1 : 2'd0;
      end
   end

endmodule

/* rtl/qspd_queue.sv */
// ----------------------------------------------------------------------------
// qspd_queue
// Four-entry result queue taking up to two items per cycle.
// ----------------------------------------------------------------------------
module qspd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               push_count,
   input  qspd_pkg::rsp_item_type   item0,
   input  qspd_pkg::rsp_item_type   item1,
   input  logic                     pop,
   output logic                     out_valid,
   output qspd_pkg::rsp_item_type   out_item,
   output qspd_pkg::queue_status_type status
);
   import qspd_pkg::*;

   rsp_item_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] wr_ptr_plus;

   assign wr_ptr_plus = wr_ptr_ff + 2'd1;
   assign wr_ptr_in   = wr_ptr_ff + push_count;
   assign rd_ptr_in   = rd_ptr_ff + {1'b0, pop};
   assign count_in    = count_ff + {1'b0, push_count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= item0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_plus] <= item1;
      end
   end

   assign out_valid    = (count_ff != 3'd0);
   assign out_item     = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.room  = (count_ff <= 3'd2);

endmodule
